// ===== rtl/bsr_pkg.sv =====
// Shared types and constants for the byte stack with rotate.
`default_nettype none
package bsr_pkg;

  localparam int StackDepth = 16;
  localparam int IdxW       = $clog2(StackDepth);
  localparam int CountW     = 5;
  localparam int ByteW      = 8;
  localparam int OpW        = 3;
  localparam int StatusW    = 2;

  localparam logic [CountW-1:0] CapReset = CountW'(StackDepth);

  typedef enum logic [OpW-1:0] {
    OpPush   = 3'd0,
    OpPop    = 3'd1,
    OpPeek   = 3'd2,
    OpDup    = 3'd3,
    OpRotUp  = 3'd4,
    OpRotDn  = 3'd5
  } opcode_e;

  typedef enum logic [2:0] {
    CmdPush,
    CmdPop,
    CmdPeek,
    CmdDup,
    CmdRotUp,
    CmdRotDn,
    CmdNop
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2,
    StSpan  = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [ByteW-1:0]  data;
    logic [CountW-1:0] span;
  } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/bsr_front.sv =====
// Request intake: decodes the opcode into a stack command for the queue.
`default_nettype none
module bsr_front (
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [bsr_pkg::OpW-1:0]    opcode_i,
  input  wire logic [bsr_pkg::ByteW-1:0]  push_byte_i,
  input  wire logic [bsr_pkg::CountW-1:0] rotate_span_i,
  output logic                          cmd_valid_o,
  input  wire logic                     cmd_ready_i,
  output bsr_pkg::cmd_t                 cmd_o
);
  import bsr_pkg::*;

  assign cmd_valid_o = in_valid_i;
  assign in_ready_o  = cmd_ready_i;

  always_comb begin
    cmd_o      = '0;
    cmd_o.cmd  = CmdNop;
    cmd_o.data = '0;
    cmd_o.span = '0;
    case (opcode_i)
      OpPush: begin
        cmd_o.cmd  = CmdPush;
        cmd_o.data = push_byte_i;
      end
      OpPop:   cmd_o.cmd = CmdPop;
      OpPeek:  cmd_o.cmd = CmdPeek;
      OpDup:   cmd_o.cmd = CmdDup;
      OpRotUp: begin
        cmd_o.cmd  = CmdRotUp;
        cmd_o.span = rotate_span_i;
      end
      OpRotDn: begin
        cmd_o.cmd  = CmdRotDn;
        cmd_o.span = rotate_span_i;
      end
      // unused opcodes do nothing and report ok
      default: cmd_o.cmd = CmdNop;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/bsr_queue.sv =====
// Two-entry command queue between the intake and the stack engine.
`default_nettype none
module bsr_queue (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    wr_valid_i,
  output logic         wr_ready_o,
  input  wire bsr_pkg::cmd_t wr_cmd_i,
  output logic         rd_valid_o,
  input  wire logic    rd_ready_i,
  output bsr_pkg::cmd_t rd_cmd_o
);
  import bsr_pkg::*;

  localparam int QDepth = 2;
  localparam int PtrW   = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  cmd_t             slot_q [QDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q;
  logic             wr_en, rd_en;

  assign wr_ready_o = (count_q != QCntW'(QDepth));
  assign rd_valid_o = (count_q != '0);
  assign wr_en      = wr_valid_i && wr_ready_o;
  assign rd_en      = rd_ready_i && rd_valid_o;
  assign rd_cmd_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_en) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (rd_en) rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({wr_en, rd_en})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) slot_q[wr_ptr_q] <= wr_cmd_i;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCntW'(QDepth))
    else $error("queue count beyond depth");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == QCntW'(QDepth)) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && !rd_en) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count missed a write");

endmodule
`default_nettype wire

// ===== rtl/bsr_back.sv =====
// Stack engine: holds the entries and count, executes commands, registers results.
`default_nettype none
module bsr_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [bsr_pkg::CountW-1:0]   cfg_data_i,
  input  wire logic                       cmd_valid_i,
  output logic                            cmd_ready_o,
  input  wire bsr_pkg::cmd_t              cmd_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [bsr_pkg::StatusW-1:0]       status_o,
  output logic [bsr_pkg::ByteW-1:0]         top_byte_o,
  output logic [bsr_pkg::CountW-1:0]        depth_o
);
  import bsr_pkg::*;

  logic [CountW-1:0] cap_q;
  logic [CountW-1:0] fill_q, fill_d;
  logic [ByteW-1:0]  entry_q [StackDepth];
  logic [ByteW-1:0]  entry_d [StackDepth];
  logic [CountW-1:0] limit;
  logic [IdxW-1:0]   span_m1;
  logic              go, is_empty, is_full;
  status_e           st_d, out_status_q;
  logic [ByteW-1:0]  out_top_q;
  logic [CountW-1:0] out_depth_q;
  logic              out_valid_q;

  assign go          = cmd_valid_i && (!out_valid_q || out_ready_i);
  assign cmd_ready_o = go;

  // clamp capacity into 1..StackDepth
  always_comb begin
    if (cap_q == '0)                         limit = CountW'(1);
    else if (cap_q > CountW'(StackDepth))    limit = CountW'(StackDepth);
    else                                     limit = cap_q;
  end

  assign is_empty = (fill_q == '0);
  assign is_full  = (fill_q >= limit);
  assign span_m1  = IdxW'(cmd_i.span - 1'b1);

  always_comb begin
    fill_d = fill_q;
    st_d   = StOk;
    for (int i = 0; i < StackDepth; i++) entry_d[i] = entry_q[i];
    case (cmd_i.cmd)
      CmdPush, CmdDup: begin
        if (cmd_i.cmd == CmdDup && is_empty) begin
          st_d = StEmpty;
        end else if (is_full) begin
          st_d = StFull;
        end else begin
          for (int i = 1; i < StackDepth; i++) entry_d[i] = entry_q[i-1];
          entry_d[0] = (cmd_i.cmd == CmdDup) ? entry_q[0] : cmd_i.data;
          fill_d     = fill_q + 1'b1;
        end
      end
      CmdPop: begin
        if (is_empty) begin
          st_d = StEmpty;
        end else begin
          for (int i = 0; i < StackDepth - 1; i++) entry_d[i] = entry_q[i+1];
          fill_d = fill_q - 1'b1;
        end
      end
      CmdPeek: begin
        if (is_empty) st_d = StEmpty;
      end
      CmdRotUp: begin
        if (is_empty) begin
          st_d = StEmpty;
        end else if (cmd_i.span > fill_q) begin
          st_d = StSpan;
        end else if (cmd_i.span >= CountW'(2)) begin
          for (int i = 0; i < StackDepth - 1; i++) begin
            if (CountW'(i + 1) < cmd_i.span) entry_d[i] = entry_q[i+1];
          end
          entry_d[span_m1] = entry_q[0];
        end
      end
      CmdRotDn: begin
        if (is_empty) begin
          st_d = StEmpty;
        end else if (cmd_i.span > fill_q) begin
          st_d = StSpan;
        end else if (cmd_i.span >= CountW'(2)) begin
          for (int i = 1; i < StackDepth; i++) begin
            if (CountW'(i) < cmd_i.span) entry_d[i] = entry_q[i-1];
          end
          entry_d[0] = entry_q[span_m1];
        end
      end
      default: st_d = StOk;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CapReset;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) cap_q <= cfg_data_i;
      if (go) fill_q <= fill_d;
      if (go)               out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      for (int i = 0; i < StackDepth; i++) entry_q[i] <= entry_d[i];
      out_status_q <= st_d;
      out_top_q    <= (fill_d == '0) ? '0 : entry_d[0];
      out_depth_q  <= fill_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign top_byte_o  = out_top_q;
  assign depth_o     = out_depth_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CountW'(StackDepth))
    else $error("stack count beyond storage");

  a_no_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && (cmd_i.cmd == CmdPeek || cmd_i.cmd == CmdRotUp || cmd_i.cmd == CmdRotDn
            || cmd_i.cmd == CmdNop)) |=> $stable(fill_q))
    else $error("count moved on a command that keeps it");

  a_depth_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go |=> (depth_o == fill_q))
    else $error("reported depth differs from stack count");

  a_empty_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && depth_o == '0) |-> (top_byte_o == '0))
    else $error("top byte not cleared on empty stack");

endmodule
`default_nettype wire

// ===== rtl/byte_stack_with_rotate_core.sv =====
// Top level of the byte stack with push, pop, peek, duplicate and rotate.
`default_nettype none
// Byte stack of 16 entries with the top at entry 0. Requests are decoded on
// entry and wait in a two-entry queue for the stack engine, which executes one
// request per cycle and holds its result in an output register; a request is
// written into the queue and then executed into the output register, and
// the sustained rate is one request per cycle while the output side keeps up.
// Every request returns status, top byte (zero on an empty stack) and depth.
// Capacity is written through cfg_we_i/cfg_data_i (reset 16; 0 acts as 1,
// values above 16 act as 16) and must only change while the block is idle.
module byte_stack_with_rotate_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [bsr_pkg::OpW-1:0]      opcode_i,
  input  wire logic [bsr_pkg::ByteW-1:0]    push_byte_i,
  input  wire logic [bsr_pkg::CountW-1:0]   rotate_span_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [bsr_pkg::StatusW-1:0]       status_o,
  output logic [bsr_pkg::ByteW-1:0]         top_byte_o,
  output logic [bsr_pkg::CountW-1:0]        depth_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [bsr_pkg::CountW-1:0]   cfg_data_i
);
  import bsr_pkg::*;

  cmd_t front_cmd, back_cmd;
  logic front_valid, front_ready;
  logic back_valid, back_ready;

  bsr_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .push_byte_i   (push_byte_i),
    .rotate_span_i (rotate_span_i),
    .cmd_valid_o   (front_valid),
    .cmd_ready_i   (front_ready),
    .cmd_o         (front_cmd)
  );

  bsr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (front_valid),
    .wr_ready_o (front_ready),
    .wr_cmd_i   (front_cmd),
    .rd_valid_o (back_valid),
    .rd_ready_i (back_ready),
    .rd_cmd_o   (back_cmd)
  );

  bsr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (back_valid),
    .cmd_ready_o (back_ready),
    .cmd_i       (back_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .top_byte_o  (top_byte_o),
    .depth_o     (depth_o)
  );

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the byte stack with push, pop, dup and rotate.
`timescale 1ns / 100ps
module tb;
  import bsr_pkg::*;

  localparam int StallLimit = 2000;
  localparam int PhaseCount = 12;
  localparam int PhaseItems = 95;
  // Opcodes outside the defined set; the block must treat them as no-ops.
  localparam logic [OpW-1:0] OpRsvdA = 3'd6;
  localparam logic [OpW-1:0] OpRsvdB = 3'd7;

  typedef struct packed {
    status_e           status;
    logic [ByteW-1:0]  top;
    logic [CountW-1:0] depth;
  } stack_result_t;

  typedef struct {
    logic              wr_cap;
    logic [CountW-1:0] cap_val;
    logic [OpW-1:0]    op;
    logic [ByteW-1:0]  data;
    logic [CountW-1:0] span;
    logic              pinned;
    stack_result_t     want;
  } dir_row_t;

  typedef enum int {MixFill, MixDrain, MixBalanced} mix_e;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [OpW-1:0]    opcode_i = OpPeek;
  logic [ByteW-1:0]  push_byte_i = '0;
  logic [CountW-1:0] rotate_span_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [StatusW-1:0] status_o;
  logic [ByteW-1:0]  top_byte_o;
  logic [CountW-1:0] depth_o;
  logic              cfg_we_i = 1'b0;
  logic [CountW-1:0] cfg_data_i = '0;

  // Fixed expectation travelling with the request that is on the bus.
  logic              pin_valid = 1'b0;
  stack_result_t     pin_result = '0;

  // Predictor state.
  logic [ByteW-1:0]  stack_mem [StackDepth];
  int unsigned       stack_fill = 0;
  logic [CountW-1:0] stack_cap = CapReset;

  stack_result_t     pending_results [$];
  int                mismatch_count = 0;
  int                idle_cycles = 0;
  int                depth_hint = 0;
  int                in_burst = 0;

  byte_stack_with_rotate_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .push_byte_i  (push_byte_i),
    .rotate_span_i(rotate_span_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .top_byte_o   (top_byte_o),
    .depth_o      (depth_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    for (int i = 0; i < StackDepth; i++) stack_mem[i] = '0;
  end

  function automatic void stack_push(logic [ByteW-1:0] b);
    for (int i = stack_fill; i > 0; i--) stack_mem[i] = stack_mem[i-1];
    stack_mem[0] = b;
    stack_fill++;
  endfunction

  function automatic stack_result_t stack_apply(logic [OpW-1:0] op, logic [ByteW-1:0] b,
                                                logic [CountW-1:0] span);
    status_e       st;
    int unsigned   lim;
    logic [ByteW-1:0] hold;
    stack_result_t r;
    st  = StOk;
    lim = 32'(stack_cap);
    if (lim < 1) lim = 1;
    if (lim > StackDepth) lim = StackDepth;
    case (op)
      OpPush: begin
        if (stack_fill >= lim) st = StFull;
        else stack_push(b);
      end
      OpPop: begin
        if (stack_fill == 0) st = StEmpty;
        else begin
          for (int i = 0; i + 1 < stack_fill; i++) stack_mem[i] = stack_mem[i+1];
          stack_fill--;
        end
      end
      OpPeek: begin
        if (stack_fill == 0) st = StEmpty;
      end
      OpDup: begin
        if (stack_fill == 0) st = StEmpty;
        else if (stack_fill >= lim) st = StFull;
        else stack_push(stack_mem[0]);
      end
      OpRotUp, OpRotDn: begin
        if (stack_fill == 0) st = StEmpty;
        else if (span > stack_fill) st = StSpan;
        else if (span >= 2) begin
          if (op == OpRotUp) begin
            hold = stack_mem[0];
            for (int i = 0; i + 1 < span; i++) stack_mem[i] = stack_mem[i+1];
            stack_mem[span-1] = hold;
          end else begin
            hold = stack_mem[span-1];
            for (int i = int'(span) - 1; i > 0; i--) stack_mem[i] = stack_mem[i-1];
            stack_mem[0] = hold;
          end
        end
      end
      default: ;
    endcase
    r.status = st;
    r.top    = (stack_fill != 0) ? stack_mem[0] : '0;
    r.depth  = stack_fill[CountW-1:0];
    return r;
  endfunction

  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Predict on accepted requests, check accepted results, run the watchdog.
  always @(posedge clk_i) begin : monitor
    stack_result_t got;
    stack_result_t want;
    if (rst_ni) begin
      if (cfg_we_i) stack_cap = cfg_data_i;
      if (in_valid_i && in_ready_o) begin
        got = stack_apply(opcode_i, push_byte_i, rotate_span_i);
        if (pin_valid) got = pin_result;
        pending_results.push_back(got);
        depth_hint <= stack_fill;
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result: status %0h top %0h depth %0d",
                   $time, status_o, top_byte_o, depth_o);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          compare_field("status", 8'(want.status), 8'(status_o));
          compare_field("top_byte", want.top, top_byte_o);
          compare_field("depth", 8'(want.depth), 8'(depth_o));
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("%0t: watchdog expired", $time);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Result-side backpressure: ready runs, occasionally long, each often followed by a stall.
  initial begin
    int run;
    int stall;
    @(posedge rst_ni);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      out_ready_i <= 1'b1;
      repeat (run) @(posedge clk_i);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  task automatic send_request(logic [OpW-1:0] op, logic [ByteW-1:0] data,
                              logic [CountW-1:0] span, logic pinned, stack_result_t want);
    int gap;
    if (in_burst > 0) begin
      in_burst--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 99) < 3) in_burst = $urandom_range(20, 60);
      gap = pick_gap();
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    push_byte_i   <= data;
    rotate_span_i <= span;
    pin_valid     <= pinned;
    pin_result    <= want;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drain every outstanding result before touching the capacity register.
  task automatic write_capacity(logic [CountW-1:0] value);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  function automatic logic [OpW-1:0] random_opcode(mix_e mix);
    int w;
    int c_push, c_dup, c_pop, c_peek, c_up, c_dn;
    w = $urandom_range(0, 99);
    case (mix)
      MixFill:  begin c_push = 45; c_dup = 60; c_pop = 70; c_peek = 75; c_up = 86; c_dn = 97; end
      MixDrain: begin c_push = 20; c_dup = 27; c_pop = 62; c_peek = 67; c_up = 80; c_dn = 95; end
      default:  begin c_push = 30; c_dup = 40; c_pop = 62; c_peek = 68; c_up = 82; c_dn = 96; end
    endcase
    if (w < c_push) return OpPush;
    if (w < c_dup)  return OpDup;
    if (w < c_pop)  return OpPop;
    if (w < c_peek) return OpPeek;
    if (w < c_up)   return OpRotUp;
    if (w < c_dn)   return OpRotDn;
    return ($urandom_range(0, 1) != 0) ? OpRsvdA : OpRsvdB;
  endfunction

  function automatic logic [CountW-1:0] random_span(int fill);
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return CountW'($urandom_range(0, fill));
    if (r < 9) return CountW'(fill + 1);
    return CountW'($urandom_range(0, 31));
  endfunction

  initial begin
    dir_row_t         dir_tab [$];
    stack_result_t    no_pin;
    int               caps [8];
    mix_e             mixes [8];
    logic [CountW-1:0] cap;
    mix_e             mix;
    logic [OpW-1:0]   op;

    no_pin = '{StOk, 8'h00, 5'd0};
    caps   = '{16, 4, 0, 31, 1, 2, 16, 9};
    mixes  = '{MixFill, MixBalanced, MixDrain, MixFill, MixBalanced, MixFill, MixBalanced,
               MixFill};
    dir_tab = '{
      // empty stack after reset
      '{1'b0, 5'd0, OpPop,   8'h00, 5'd0,  1'b1, '{StEmpty, 8'h00, 5'd0}},
      '{1'b0, 5'd0, OpPeek,  8'h00, 5'd0,  1'b1, '{StEmpty, 8'h00, 5'd0}},
      '{1'b0, 5'd0, OpDup,   8'h00, 5'd0,  1'b1, '{StEmpty, 8'h00, 5'd0}},
      '{1'b0, 5'd0, OpRotUp, 8'h00, 5'd0,  1'b1, '{StEmpty, 8'h00, 5'd0}},
      '{1'b0, 5'd0, OpRotDn, 8'h00, 5'd31, 1'b1, '{StEmpty, 8'h00, 5'd0}},
      '{1'b0, 5'd0, OpRsvdA, 8'hFF, 5'd31, 1'b1, '{StOk,    8'h00, 5'd0}},
      '{1'b0, 5'd0, OpPush,  8'hFF, 5'd0,  1'b1, '{StOk,    8'hFF, 5'd1}},
      '{1'b0, 5'd0, OpPush,  8'h00, 5'd31, 1'b1, '{StOk,    8'h00, 5'd2}},
      // span beyond depth
      '{1'b0, 5'd0, OpRotUp, 8'h00, 5'd3,  1'b1, '{StSpan,  8'h00, 5'd2}},
      '{1'b0, 5'd0, OpRotDn, 8'h00, 5'd31, 1'b1, '{StSpan,  8'h00, 5'd2}},
      '{1'b0, 5'd0, OpRotUp, 8'h00, 5'd2,  1'b0, no_pin},
      '{1'b0, 5'd0, OpRotUp, 8'h00, 5'd0,  1'b0, no_pin},
      '{1'b0, 5'd0, OpRotDn, 8'h00, 5'd1,  1'b0, no_pin},
      '{1'b0, 5'd0, OpDup,   8'h00, 5'd0,  1'b0, no_pin},
      '{1'b0, 5'd0, OpPush,  8'hA5, 5'd0,  1'b0, no_pin},
      '{1'b0, 5'd0, OpPush,  8'h5A, 5'd0,  1'b0, no_pin},
      '{1'b0, 5'd0, OpRotUp, 8'h00, 5'd5,  1'b0, no_pin},
      '{1'b0, 5'd0, OpRotDn, 8'h00, 5'd5,  1'b0, no_pin},
      '{1'b0, 5'd0, OpRsvdB, 8'h00, 5'd16, 1'b0, no_pin},
      '{1'b0, 5'd0, OpPeek,  8'h00, 5'd0,  1'b0, no_pin},
      '{1'b0, 5'd0, OpPop,   8'h00, 5'd0,  1'b0, no_pin},
      // capacity dropped below the held depth
      '{1'b1, 5'd1, OpPush,  8'h3C, 5'd0,  1'b1, '{StFull,  8'hA5, 5'd4}},
      '{1'b0, 5'd0, OpDup,   8'h00, 5'd0,  1'b1, '{StFull,  8'hA5, 5'd4}},
      '{1'b0, 5'd0, OpPop,   8'h00, 5'd0,  1'b0, no_pin}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].wr_cap) write_capacity(dir_tab[i].cap_val);
      send_request(dir_tab[i].op, dir_tab[i].data, dir_tab[i].span, dir_tab[i].pinned,
                   dir_tab[i].want);
    end

    for (int p = 0; p < PhaseCount; p++) begin
      if (p < 8) begin
        cap = CountW'(caps[p]);
        mix = mixes[p];
      end else begin
        cap = CountW'($urandom_range(0, 31));
        mix = mix_e'($urandom_range(0, 2));
      end
      write_capacity(cap);
      repeat (PhaseItems) begin
        op = random_opcode(mix);
        send_request(op, ByteW'($urandom_range(0, 255)), random_span(depth_hint), 1'b0,
                     no_pin);
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
